FILE: rtl/core/lut_1d_linear_interpolation_macros.svh
//------------------------------------------------------------------------------
// Assertion macros for the 1-D lookup table with linear interpolation
// Clocked on clk, disabled while arst_n is low.
//------------------------------------------------------------------------------
`ifndef LUT_1D_LINEAR_INTERPOLATION_MACROS_SVH
`define LUT_1D_LINEAR_INTERPOLATION_MACROS_SVH

// same-cycle implication
`define LUT1D_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LUT1D_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lut1d_pkg.sv
//------------------------------------------------------------------------------
// lut1d_pkg
// Constants and types of the 1-D lookup table with linear interpolation.
//------------------------------------------------------------------------------
`default_nettype none

package lut1d_pkg;

	localparam int NUM_W   = 32;
	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int LEN_W   = IDX_W + 1;
	localparam int PROD_W  = 2 * NUM_W;
	localparam int QLO_W   = 41;
	localparam int QHI_W   = PROD_W - QLO_W;
	localparam int CNT_W   = $clog2(QLO_W);
	localparam int RES_W   = QLO_W + 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QLO_W - 1);
	localparam logic [QLO_W-1:0] Q_MAX    = QLO_W'(1) << (QLO_W - 1);

	localparam logic signed [RES_W-1:0] R_HI = RES_W'((64'sd1 <<< (NUM_W - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0] R_LO = RES_W'(-(64'sd1 <<< (NUM_W - 1)));

	typedef struct packed {
		logic signed [NUM_W-1:0] bp;
		logic signed [NUM_W-1:0] val;
	} entry_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_ENDS  = 10'b00_0000_0010,
		ST_SADDR = 10'b00_0000_0100,
		ST_SCMP  = 10'b00_0000_1000,
		ST_FETCH = 10'b00_0001_0000,
		ST_DIFF  = 10'b00_0010_0000,
		ST_MUL   = 10'b00_0100_0000,
		ST_DINIT = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lut_1d_linear_interpolation.sv
// Load item: written to the table on accept, busy stays low, no result.
// Query item: when x is clamped to an end value, the result strobe follows the end check;
// otherwise up to 6 search steps run, each a registered table read and a compare, then
// fetch, difference and multiply, then the bit-serial divider (41 quotient bits) unless a
// flat segment or saturating quotient. Busy drops with the strobe; receiver cannot stall.
// Reset clears the sequencer, the strobe and table_length (to 1); table contents stay.
//------------------------------------------------------------------------------
// lut_1d_linear_interpolation
// Breakpoint/value table with clamped linear interpolation: a binary search
// compare over the breakpoints, then a multiply and a restoring divide.
//------------------------------------------------------------------------------
`default_nettype none
`include "lut_1d_linear_interpolation_macros.svh"

module lut_1d_linear_interpolation (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   cmd,
	input  wire logic [lut1d_pkg::IDX_W-1:0]            entry_index,
	input  wire logic signed [lut1d_pkg::NUM_W-1:0]     entry_breakpoint,
	input  wire logic signed [lut1d_pkg::NUM_W-1:0]     entry_value,
	input  wire logic signed [lut1d_pkg::NUM_W-1:0]     query_x,
	output logic                                        result_valid,
	output logic signed [lut1d_pkg::NUM_W-1:0]          result_value,
	input  wire logic                                   table_length_we,
	input  wire logic [lut1d_pkg::LEN_W-1:0]            table_length_wdata
);

	lut1d_pkg::state_t state_q;

	lut1d_pkg::entry_t mem_q [lut1d_pkg::DEPTH];
	lut1d_pkg::entry_t rd_a_q;
	lut1d_pkg::entry_t rd_b_q;
	logic [lut1d_pkg::IDX_W-1:0] addr_a;
	logic [lut1d_pkg::IDX_W-1:0] addr_b;

	logic [lut1d_pkg::IDX_W-1:0]           len_m1_q;
	logic signed [lut1d_pkg::NUM_W-1:0]    x_q;
	logic signed [lut1d_pkg::LEN_W-1:0]    left_q;
	logic signed [lut1d_pkg::LEN_W-1:0]    right_q;
	logic signed [lut1d_pkg::LEN_W-1:0]    left_nx;
	logic signed [lut1d_pkg::LEN_W-1:0]    right_nx;
	logic signed [lut1d_pkg::LEN_W-1:0]    span;
	logic [lut1d_pkg::IDX_W-1:0]           mid;
	logic [lut1d_pkg::IDX_W-1:0]           mid_q;
	logic [lut1d_pkg::IDX_W-1:0]           idx_q;

	logic signed [lut1d_pkg::NUM_W:0]      dx;
	logic signed [lut1d_pkg::NUM_W:0]      dy;
	logic signed [lut1d_pkg::NUM_W:0]      dq;
	logic [lut1d_pkg::NUM_W-1:0]           mdx_q;
	logic [lut1d_pkg::NUM_W-1:0]           mdy_q;
	logic [lut1d_pkg::NUM_W-1:0]           mdq_q;
	logic                                  neg_q;
	logic                                  dxz_q;
	logic signed [lut1d_pkg::NUM_W-1:0]    y0_q;
	logic [lut1d_pkg::PROD_W-1:0]          prod_q;

	logic [lut1d_pkg::NUM_W-1:0]           rem_q;
	logic [lut1d_pkg::QLO_W-1:0]           sh_q;
	logic [lut1d_pkg::CNT_W-1:0]           cnt_q;
	logic [lut1d_pkg::NUM_W:0]             trial;
	logic                                  trial_ok;

	logic [lut1d_pkg::QLO_W-1:0]           q_sat;
	logic signed [lut1d_pkg::RES_W-1:0]    r_full;
	logic signed [lut1d_pkg::NUM_W-1:0]    r_sat;

	logic                                  load_we;
	logic                                  query_go;
	logic                                  hit;

	assign busy     = (state_q != lut1d_pkg::ST_IDLE);
	assign load_we  = start && !busy && (cmd == lut1d_pkg::CMD_LOAD);
	assign query_go = start && !busy && (cmd == lut1d_pkg::CMD_QUERY);

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem_q[entry_index] <= '{bp: entry_breakpoint, val: entry_value};
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
	end

	always_comb begin
		case (state_q)
			lut1d_pkg::ST_IDLE: begin
				addr_a = '0;
				addr_b = len_m1_q;
			end
			lut1d_pkg::ST_SADDR: begin
				addr_a = mid;
				addr_b = mid + lut1d_pkg::IDX_W'(1);
			end
			lut1d_pkg::ST_FETCH: begin
				addr_a = idx_q;
				addr_b = idx_q + lut1d_pkg::IDX_W'(1);
			end
			default: begin
				addr_a = '0;
				addr_b = '0;
			end
		endcase
	end

	assign span = right_q - left_q;
	assign mid  = lut1d_pkg::IDX_W'(left_q + (span >>> 1));

	assign hit = (x_q >= rd_a_q.bp) && (x_q < rd_b_q.bp);

	always_comb begin
		left_nx  = left_q;
		right_nx = right_q;
		if (x_q < rd_a_q.bp) begin
			right_nx = lut1d_pkg::LEN_W'(mid_q) - lut1d_pkg::LEN_W'(1);
		end else begin
			left_nx = lut1d_pkg::LEN_W'(mid_q) + lut1d_pkg::LEN_W'(1);
		end
	end

	assign dx = {rd_b_q.bp[lut1d_pkg::NUM_W-1], rd_b_q.bp}
		- {rd_a_q.bp[lut1d_pkg::NUM_W-1], rd_a_q.bp};
	assign dy = {rd_b_q.val[lut1d_pkg::NUM_W-1], rd_b_q.val}
		- {rd_a_q.val[lut1d_pkg::NUM_W-1], rd_a_q.val};
	assign dq = {x_q[lut1d_pkg::NUM_W-1], x_q}
		- {rd_a_q.bp[lut1d_pkg::NUM_W-1], rd_a_q.bp};

	assign trial    = {rem_q, sh_q[lut1d_pkg::QLO_W-1]} - {1'b0, mdx_q};
	assign trial_ok = !trial[lut1d_pkg::NUM_W];

	assign q_sat  = (sh_q > lut1d_pkg::Q_MAX) ? lut1d_pkg::Q_MAX : sh_q;
	assign r_full = neg_q
		? (lut1d_pkg::RES_W'(y0_q) - $signed({2'b00, q_sat}))
		: (lut1d_pkg::RES_W'(y0_q) + $signed({2'b00, q_sat}));

	always_comb begin
		if (r_full > lut1d_pkg::R_HI) begin
			r_sat = lut1d_pkg::NUM_W'(lut1d_pkg::R_HI);
		end else if (r_full < lut1d_pkg::R_LO) begin
			r_sat = lut1d_pkg::NUM_W'(lut1d_pkg::R_LO);
		end else begin
			r_sat = r_full[lut1d_pkg::NUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_m1_q <= '0;
		end else if (table_length_we) begin
			if (table_length_wdata == '0) begin
				len_m1_q <= '0;
			end else if (table_length_wdata > lut1d_pkg::LEN_W'(lut1d_pkg::DEPTH)) begin
				len_m1_q <= lut1d_pkg::IDX_W'(lut1d_pkg::DEPTH - 1);
			end else begin
				len_m1_q <= lut1d_pkg::IDX_W'(table_length_wdata - lut1d_pkg::LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lut1d_pkg::ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				lut1d_pkg::ST_IDLE: begin
					if (query_go) begin
						state_q <= lut1d_pkg::ST_ENDS;
					end
				end
				lut1d_pkg::ST_ENDS: begin
					if (x_q <= rd_a_q.bp || x_q >= rd_b_q.bp) begin
						result_valid <= 1'b1;
						state_q      <= lut1d_pkg::ST_IDLE;
					end else begin
						state_q <= lut1d_pkg::ST_SADDR;
					end
				end
				lut1d_pkg::ST_SADDR: begin
					state_q <= lut1d_pkg::ST_SCMP;
				end
				lut1d_pkg::ST_SCMP: begin
					if (hit || (x_q < rd_a_q.bp && mid_q == '0) || left_nx > right_nx) begin
						state_q <= lut1d_pkg::ST_FETCH;
					end else begin
						state_q <= lut1d_pkg::ST_SADDR;
					end
				end
				lut1d_pkg::ST_FETCH: begin
					state_q <= lut1d_pkg::ST_DIFF;
				end
				lut1d_pkg::ST_DIFF: begin
					state_q <= lut1d_pkg::ST_MUL;
				end
				lut1d_pkg::ST_MUL: begin
					if (dxz_q) begin
						result_valid <= 1'b1;
						state_q      <= lut1d_pkg::ST_IDLE;
					end else begin
						state_q <= lut1d_pkg::ST_DINIT;
					end
				end
				lut1d_pkg::ST_DINIT: begin
					if (lut1d_pkg::NUM_W'(prod_q[lut1d_pkg::PROD_W-1 -: lut1d_pkg::QHI_W])
						>= mdx_q) begin
						state_q <= lut1d_pkg::ST_FIN;
					end else begin
						state_q <= lut1d_pkg::ST_DIV;
					end
				end
				lut1d_pkg::ST_DIV: begin
					if (cnt_q == lut1d_pkg::DIV_LAST) begin
						state_q <= lut1d_pkg::ST_FIN;
					end
				end
				lut1d_pkg::ST_FIN: begin
					result_valid <= 1'b1;
					state_q      <= lut1d_pkg::ST_IDLE;
				end
				default: begin
					state_q <= lut1d_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			lut1d_pkg::ST_IDLE: begin
				if (query_go) begin
					x_q <= query_x;
				end
			end
			lut1d_pkg::ST_ENDS: begin
				if (x_q <= rd_a_q.bp) begin
					result_value <= rd_a_q.val;
				end else begin
					result_value <= rd_b_q.val;
				end
				left_q  <= '0;
				right_q <= lut1d_pkg::LEN_W'(len_m1_q) - lut1d_pkg::LEN_W'(1);
			end
			lut1d_pkg::ST_SADDR: begin
				mid_q <= mid;
			end
			lut1d_pkg::ST_SCMP: begin
				left_q  <= left_nx;
				right_q <= right_nx;
				if (hit) begin
					idx_q <= mid_q;
				end else begin
					idx_q <= '0;
				end
			end
			lut1d_pkg::ST_DIFF: begin
				mdx_q <= dx[lut1d_pkg::NUM_W] ? lut1d_pkg::NUM_W'(-dx) : lut1d_pkg::NUM_W'(dx);
				mdy_q <= dy[lut1d_pkg::NUM_W] ? lut1d_pkg::NUM_W'(-dy) : lut1d_pkg::NUM_W'(dy);
				mdq_q <= dq[lut1d_pkg::NUM_W] ? lut1d_pkg::NUM_W'(-dq) : lut1d_pkg::NUM_W'(dq);
				neg_q <= dx[lut1d_pkg::NUM_W] ^ dy[lut1d_pkg::NUM_W] ^ dq[lut1d_pkg::NUM_W];
				dxz_q <= (dx == '0);
				y0_q  <= rd_a_q.val;
			end
			lut1d_pkg::ST_MUL: begin
				prod_q <= lut1d_pkg::PROD_W'(mdy_q) * lut1d_pkg::PROD_W'(mdq_q);
				if (dxz_q) begin
					result_value <= y0_q;
				end
			end
			lut1d_pkg::ST_DINIT: begin
				rem_q <= lut1d_pkg::NUM_W'(prod_q[lut1d_pkg::PROD_W-1 -: lut1d_pkg::QHI_W]);
				cnt_q <= '0;
				if (lut1d_pkg::NUM_W'(prod_q[lut1d_pkg::PROD_W-1 -: lut1d_pkg::QHI_W])
					>= mdx_q) begin
					sh_q <= lut1d_pkg::Q_MAX;
				end else begin
					sh_q <= prod_q[lut1d_pkg::QLO_W-1:0];
				end
			end
			lut1d_pkg::ST_DIV: begin
				cnt_q <= cnt_q + lut1d_pkg::CNT_W'(1);
				if (trial_ok) begin
					rem_q <= trial[lut1d_pkg::NUM_W-1:0];
				end else begin
					rem_q <= {rem_q[lut1d_pkg::NUM_W-2:0], sh_q[lut1d_pkg::QLO_W-1]};
				end
				sh_q <= {sh_q[lut1d_pkg::QLO_W-2:0], trial_ok};
			end
			lut1d_pkg::ST_FIN: begin
				result_value <= r_sat;
			end
			default: begin
			end
		endcase
	end

	`LUT1D_ASSERT_IMP(a_strobe_idle, result_valid, state_q == lut1d_pkg::ST_IDLE, "result strobe while sequencer busy")
	`LUT1D_ASSERT_NXT(a_query_busy, query_go, busy && !result_valid, "accepted query did not start sequencer")
	`LUT1D_ASSERT_NXT(a_strobe_pulse, result_valid, !result_valid, "result strobe longer than one cycle")
	`LUT1D_ASSERT_IMP(a_search_window, state_q == lut1d_pkg::ST_SADDR, left_q <= right_q, "search window empty at address step")
	`LUT1D_ASSERT_IMP(a_div_count, state_q == lut1d_pkg::ST_DIV, cnt_q <= lut1d_pkg::DIV_LAST, "divider ran past last quotient bit")

endmodule

`default_nettype wire

FILE: tb/tb_lut_1d_linear_interpolation.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_lut_1d_linear_interpolation
// Loads breakpoint/value tables of many lengths, mostly ordered with random
// content plus stray loads that break the order, and checks every query result
// against a predictor that tracks the table and the length in use.
//------------------------------------------------------------------------------

module tb_lut_1d_linear_interpolation;

	localparam longint NUM_MAX       = (longint'(1) <<< (lut1d_pkg::NUM_W - 1)) - 1;
	localparam longint NUM_MIN       = -NUM_MAX - 1;
	localparam int     IDLE_PCT      = 28;
	localparam int     RANDOM_ITEMS  = 1500;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     CALM_FROM     = 20000;
	localparam int     CALM_TO       = 40000;
	localparam int     CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic                               cmd;
		logic [lut1d_pkg::IDX_W-1:0]        idx;
		logic signed [lut1d_pkg::NUM_W-1:0] bp;
		logic signed [lut1d_pkg::NUM_W-1:0] val;
		logic signed [lut1d_pkg::NUM_W-1:0] x;
	} lut_item_t;

	logic                               clk                = 1'b0;
	logic                               arst_n             = 1'b0;
	logic                               start              = 1'b0;
	logic                               busy;
	logic                               cmd                = lut1d_pkg::CMD_LOAD;
	logic [lut1d_pkg::IDX_W-1:0]        entry_index        = '0;
	logic signed [lut1d_pkg::NUM_W-1:0] entry_breakpoint   = '0;
	logic signed [lut1d_pkg::NUM_W-1:0] entry_value        = '0;
	logic signed [lut1d_pkg::NUM_W-1:0] query_x            = '0;
	logic                               result_valid;
	logic signed [lut1d_pkg::NUM_W-1:0] result_value;
	logic                               table_length_we    = 1'b0;
	logic [lut1d_pkg::LEN_W-1:0]        table_length_wdata = '0;

	lut_item_t                          pending_items[$];
	lut_item_t                          cur;
	logic signed [lut1d_pkg::NUM_W-1:0] expected_values[$];
	logic signed [lut1d_pkg::NUM_W-1:0] want;
	logic signed [lut1d_pkg::NUM_W-1:0] bp_tab [lut1d_pkg::DEPTH];
	logic signed [lut1d_pkg::NUM_W-1:0] val_tab [lut1d_pkg::DEPTH];
	int                                 table_len = 1;
	int                                 queued = 0;
	int                                 errors = 0;
	int unsigned                        cycles = 0;
	logic                               calm;

	lut_1d_linear_interpolation DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.entry_index       (entry_index),
		.entry_breakpoint  (entry_breakpoint),
		.entry_value       (entry_value),
		.query_x           (query_x),
		.result_valid      (result_valid),
		.result_value      (result_value),
		.table_length_we   (table_length_we),
		.table_length_wdata(table_length_wdata)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

	function automatic logic signed [lut1d_pkg::NUM_W-1:0] interpolate_at(
		input logic signed [lut1d_pkg::NUM_W-1:0] x);
		int          seg;
		int          left;
		int          right;
		int          mid;
		longint      x0, x1, y0, y1, dx, dy, dq, r;
		bit [63:0]   q;
		bit          neg;
		seg   = 0;
		left  = 0;
		right = table_len - 2;
		if (x <= bp_tab[0])
			return val_tab[0];
		if (x >= bp_tab[table_len-1])
			return val_tab[table_len-1];
		while (left <= right) begin
			mid = left + ((right - left) >>> 1);
			if (x >= bp_tab[mid] && x < bp_tab[mid+1]) begin
				seg = mid;
				break;
			end else if (x < bp_tab[mid]) begin
				if (mid == 0)
					break;
				right = mid - 1;
			end else begin
				left = mid + 1;
			end
		end
		x0 = bp_tab[seg];
		x1 = bp_tab[seg+1];
		y0 = val_tab[seg];
		y1 = val_tab[seg+1];
		dx = x1 - x0;
		if (dx == 0)
			return y0[lut1d_pkg::NUM_W-1:0];
		dy  = y1 - y0;
		dq  = longint'(x) - x0;
		neg = ((dy < 0) != (dq < 0)) != (dx < 0);
		q   = ($unsigned(dy < 0 ? -dy : dy) * $unsigned(dq < 0 ? -dq : dq))
			/ $unsigned(dx < 0 ? -dx : dx);
		if (q > (64'd1 << 40))
			q = 64'd1 << 40;
		r = neg ? y0 - longint'(q) : y0 + longint'(q);
		if (r > NUM_MAX)
			r = NUM_MAX;
		if (r < NUM_MIN)
			r = NUM_MIN;
		return r[lut1d_pkg::NUM_W-1:0];
	endfunction

	// driver: accept, predict, then present the next item or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				if (cur.cmd == lut1d_pkg::CMD_LOAD) begin
					bp_tab[cur.idx]  = cur.bp;
					val_tab[cur.idx] = cur.val;
				end else begin
					expected_values.push_back(interpolate_at(cur.x));
				end
			end
			if (!start || !busy) begin
				if (pending_items.size() != 0 &&
				    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cur = pending_items.pop_front();
					start            <= 1'b1;
					cmd              <= cur.cmd;
					entry_index      <= cur.idx;
					entry_breakpoint <= cur.bp;
					entry_value      <= cur.val;
					query_x          <= cur.x;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_values.size() == 0) begin
				$error("result_value: no result expected, actual %0d", result_value);
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (result_value !== want) begin
					$error("result_value: expected %0d, actual %0d", want, result_value);
					errors++;
				end
			end
		end
	end

	task automatic push_load(input int unsigned idx,
	                         input logic signed [lut1d_pkg::NUM_W-1:0] b,
	                         input logic signed [lut1d_pkg::NUM_W-1:0] v);
		lut_item_t it;
		it     = '0;
		it.cmd = lut1d_pkg::CMD_LOAD;
		it.idx = idx[lut1d_pkg::IDX_W-1:0];
		it.bp  = b;
		it.val = v;
		it.x   = $urandom();
		pending_items.push_back(it);
		queued++;
	endtask

	task automatic push_query(input logic signed [lut1d_pkg::NUM_W-1:0] x);
		lut_item_t it;
		it     = '0;
		it.cmd = lut1d_pkg::CMD_QUERY;
		it.idx = lut1d_pkg::IDX_W'($urandom());
		it.bp  = $urandom();
		it.val = $urandom();
		it.x   = x;
		pending_items.push_back(it);
		queued++;
	endtask

	// wait until every item is taken and every result is in, then let loads finish
	task automatic settle();
		while (pending_items.size() != 0 || start || expected_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [lut1d_pkg::LEN_W-1:0] v);
		settle();
		table_length_we    <= 1'b1;
		table_length_wdata <= v;
		table_len = (v == 0) ? 1 : (v > lut1d_pkg::DEPTH) ? lut1d_pkg::DEPTH : int'(v);
		@(posedge clk);
		table_length_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		longint                      gen_bp [lut1d_pkg::DEPTH];
		longint                      bl, lo, hi, xl;
		bit [63:0]                   rnd;
		logic [lut1d_pkg::LEN_W-1:0] wlen;
		int unsigned                 step;
		int                          i, j, n, nq, phase, shape, pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one entry in use after reset
		push_load(0, 32'h0001_0000, 32'h7FFF_FFFF);
		push_query(32'h8000_0000);
		push_query(32'h0001_0000);
		push_query(32'h7FFF_FFFF);

		// widest possible segment and slope
		set_length(2);
		push_load(0, 32'h8000_0000, 32'h8000_0000);
		push_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_query(32'h0000_0000);
		push_query(32'hFFFF_FFFF);
		push_query(32'h7FFF_FFFE);
		push_query(32'h8000_0001);

		// zero length runs as one entry
		set_length(0);
		push_query(32'h0000_0005);

		// equal breakpoints in the middle between rising segments
		set_length(4);
		push_load(0, 32'hFFFF_0000, 32'h0001_0000);
		push_load(1, 32'h0000_0000, 32'h7FFF_FFFF);
		push_load(2, 32'h0000_0000, 32'h8000_0000);
		push_load(3, 32'h0003_0000, 32'h0000_0000);
		push_query(32'h0000_0000);
		push_query(32'hFFFF_FFFF);
		push_query(32'h0001_7FFF);

		queued = 0;
		phase  = 0;
		while (queued < RANDOM_ITEMS) begin
			case (phase)
				0: wlen = 7'd127;
				1: wlen = 7'd1;
				2: wlen = 7'd64;
				default: begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						wlen = '0;
					else if (pick == 1)
						wlen = lut1d_pkg::LEN_W'($urandom_range(65, 127));
					else if (pick == 2)
						wlen = 7'd64;
					else
						wlen = lut1d_pkg::LEN_W'($urandom_range(1, 12));
				end
			endcase
			set_length(wlen);
			n     = table_len;
			shape = $urandom_range(0, 9);
			case (shape)
				0:       step = 3;
				1, 2:    step = 32'h0001_0000;
				4, 5, 6: step = 32'h0100_0000;
				default: step = 32'hFFFF_FFFF / n;
			endcase
			if (shape == 3 || shape == 7 || shape == 8)
				bl = NUM_MIN + $urandom_range(0, 255);
			else
				bl = int'($urandom());
			for (i = 0; i < n; i++) begin
				if (shape == 9)
					bl = int'($urandom());
				else if (i != 0)
					bl = bl + $urandom_range(0, step);
				if (bl > NUM_MAX)
					bl = NUM_MAX;
				gen_bp[i] = bl;
				if ($urandom_range(0, 15) == 0)
					push_load(i, lut1d_pkg::NUM_W'(bl),
					          $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
				else
					push_load(i, lut1d_pkg::NUM_W'(bl), $urandom());
			end

			lo = gen_bp[0] - 16;
			hi = gen_bp[n-1] + 16;
			if (hi < lo)
				hi = lo;
			nq = $urandom_range(20, 60);
			for (j = 0; j < nq; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_load($urandom_range(0, lut1d_pkg::DEPTH - 1), $urandom(), $urandom());
				end else begin
					case ($urandom_range(0, 9))
						0: xl = int'($urandom());
						1: xl = gen_bp[$urandom_range(0, n - 1)];
						2: xl = gen_bp[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
						default: begin
							rnd = {$urandom(), $urandom()};
							xl  = lo + longint'(rnd % $unsigned(hi - lo + 1));
						end
					endcase
					if (xl > NUM_MAX)
						xl = NUM_MAX;
					if (xl < NUM_MIN)
						xl = NUM_MIN;
					push_query(lut1d_pkg::NUM_W'(xl));
				end
			end
			phase++;
		end

		settle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
